// File: sv/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// types and codes shared by the trial division prime tester modules
// ----------------------------------------------------------------------------
package tdpt_pkg;

	localparam int VALUE_W = 64;
	localparam int COUNT_W = 13;
	localparam int LIMIT_W = 33;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TEST   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_OVERSIZE = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               prime_flag;
		logic               test_done;
		logic [VALUE_W-1:0] echo_value;
		logic [COUNT_W-1:0] table_entries;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_CHECK,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture item, reset walk index
		logic rd;        // read table at walk index
		logic div_start; // start modulo of candidate by read entry
		logic step;      // advance walk index
		logic finish;    // emit result
		logic prime;     // verdict for test results
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] command;
		logic       more;      // walk index below entry count
		logic       div_busy;
		logic       divides;   // entry nonzero and remainder zero
		logic       over;      // entry above divisor limit
	} dp_stat_t;

endpackage

// File: sv/tdpt_ram.sv
// ----------------------------------------------------------------------------
// tdpt_ram
// single port ram, registered read
// ----------------------------------------------------------------------------
module tdpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		if (re) rdata <= mem_q[addr];
	end
endmodule

// File: sv/tdpt_mod.sv
// ----------------------------------------------------------------------------
// tdpt_mod
// restoring modulo, 64 bit dividend by narrow divisor, one bit per cycle
// ----------------------------------------------------------------------------
module tdpt_mod #(
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic          rem_zero
);
	logic [63:0]   num_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] div_q;
	logic [6:0]    cnt_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;

	assign shifted  = {rem_q[DW-1:0], num_q[63]};
	assign diff     = shifted - {1'b0, div_q};
	assign busy     = (cnt_q != 7'd0);
	assign rem_zero = (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[62:0], 1'b0};
			rem_q <= diff[DW] ? shifted : diff;
		end
	end
endmodule

// File: sv/tdpt_datapath.sv
// ----------------------------------------------------------------------------
// tdpt_datapath
// item registers, prime table, entry count, walk index and modulo unit
// ----------------------------------------------------------------------------
module tdpt_datapath #(
	parameter int TABLE_DEPTH = 4096,
	parameter int PRIME_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tdpt_pkg::in_item_t                  in_item,
	input  logic [tdpt_pkg::LIMIT_W-1:0]        limit,
	input  tdpt_pkg::dp_cmd_t                   cmd,
	output tdpt_pkg::dp_stat_t                  stat,
	output tdpt_pkg::out_item_t                 out_item
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [1:0]                   cmd_q;
	logic [tdpt_pkg::VALUE_W-1:0] val_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                idx_q;
	logic [PRIME_WIDTH-1:0]       rdata;
	logic                         oversize;
	logic                         full;
	logic                         we;
	logic                         div_busy;
	logic                         rem_zero;
	logic [AW-1:0]                addr;
	logic [1:0]                   st;

	assign oversize = (val_q >> PRIME_WIDTH) != '0;
	assign full     = (count_q >= CW'(TABLE_DEPTH));
	assign we       = cmd.finish && cmd_q == tdpt_pkg::CMD_APPEND && !oversize && !full;
	assign addr     = we ? count_q[AW-1:0] : idx_q[AW-1:0];

	tdpt_ram #(.WIDTH(PRIME_WIDTH), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .re(cmd.rd), .addr(addr),
		.wdata(val_q[PRIME_WIDTH-1:0]), .rdata(rdata)
	);

	tdpt_mod #(.DW(PRIME_WIDTH)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(val_q),
		.divisor(rdata), .busy(div_busy), .rem_zero(rem_zero)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_item.command;
			val_q <= in_item.value;
			idx_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.finish && cmd_q == tdpt_pkg::CMD_CLEAR) begin
			count_q <= '0;
		end else if (we) begin
			count_q <= count_q + CW'(1);
		end
	end

	assign stat.command  = cmd_q;
	assign stat.more     = idx_q < count_q;
	assign stat.div_busy = div_busy;
	assign stat.divides  = (rdata != '0) && rem_zero;
	assign stat.over     = {{(tdpt_pkg::LIMIT_W-PRIME_WIDTH){1'b0}}, rdata} > limit;

	always_comb begin
		st = tdpt_pkg::ST_OK;
		if (cmd_q == tdpt_pkg::CMD_APPEND) begin
			if (oversize) st = tdpt_pkg::ST_OVERSIZE;
			else if (full) st = tdpt_pkg::ST_FULL;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_item.status     <= st;
			out_item.prime_flag <= cmd.prime;
			out_item.test_done  <= (cmd_q == tdpt_pkg::CMD_TEST);
			out_item.echo_value <= val_q;
			if (cmd_q == tdpt_pkg::CMD_CLEAR)
				out_item.table_entries <= '0;
			else
				out_item.table_entries <= tdpt_pkg::COUNT_W'(count_q + CW'(we));
		end
	end
endmodule

// File: sv/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// sequencer for table commands and the trial division walk
// ----------------------------------------------------------------------------
module tdpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                strobe,
	output tdpt_pkg::dp_cmd_t   cmd,
	input  tdpt_pkg::dp_stat_t  stat
);
	tdpt_pkg::state_t state_q, state_d;
	logic             prime_q, prime_d;
	logic             strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tdpt_pkg::S_IDLE;
			prime_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			prime_q  <= prime_d;
			strobe_q <= cmd.finish;
		end
	end

	assign busy   = (state_q != tdpt_pkg::S_IDLE);
	assign strobe = strobe_q;

	always_comb begin
		state_d = state_q;
		prime_d = prime_q;
		cmd     = '0;
		cmd.prime = prime_q;
		case (state_q)
			tdpt_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					prime_d  = 1'b0;
					state_d  = tdpt_pkg::S_READ;
				end
			end
			tdpt_pkg::S_READ: begin
				if (stat.command == tdpt_pkg::CMD_TEST && stat.more) begin
					cmd.rd  = 1'b1;
					state_d = tdpt_pkg::S_DIV;
				end else begin
					cmd.prime = (stat.command == tdpt_pkg::CMD_TEST);
					cmd.finish = 1'b1;
					state_d = tdpt_pkg::S_IDLE;
				end
			end
			tdpt_pkg::S_DIV: begin
				cmd.div_start = 1'b1;
				state_d = tdpt_pkg::S_CHECK;
			end
			tdpt_pkg::S_CHECK: begin
				if (!stat.div_busy) begin
					if (stat.divides) begin
						cmd.prime  = 1'b0;
						cmd.finish = 1'b1;
						state_d    = tdpt_pkg::S_IDLE;
					end else if (stat.over) begin
						cmd.prime  = 1'b1;
						cmd.finish = 1'b1;
						state_d    = tdpt_pkg::S_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = tdpt_pkg::S_READ;
					end
				end
			end
			default: state_d = tdpt_pkg::S_IDLE;
		endcase
	end
endmodule

// File: sv/trial_division_prime_tester.sv
// ----------------------------------------------------------------------------
// trial_division_prime_tester
// prime table with clear and append, trial division test of 64 bit candidates
// ----------------------------------------------------------------------------
// channel   signals                     handshake
// item in   start, busy, in_item        taken when start high and busy low
// result    strobe, out_item            one cycle, cannot be held off
// config    limit_we, limit_wdata       written when limit_we high
//
// clear, append and unused codes pass from idle through the read state to the strobe
// a test walks the table in order, each entry tried taking the read, div and check
// states and the one bit per cycle modulo unit
// arst_n clears the entry count, the controller and the limit to 2^32
// table contents are undefined until appended
// busy stays high from acceptance until the result strobe
// ----------------------------------------------------------------------------
module trial_division_prime_tester #(
	parameter int TABLE_DEPTH = 4096,
	parameter int PRIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tdpt_pkg::in_item_t            in_item,
	output logic                          strobe,
	output tdpt_pkg::out_item_t           out_item,
	input  logic                          limit_we,
	input  logic [tdpt_pkg::LIMIT_W-1:0]  limit_wdata
);
	logic [tdpt_pkg::LIMIT_W-1:0] limit_q;
	tdpt_pkg::dp_cmd_t            dcmd;
	tdpt_pkg::dp_stat_t           dstat;

	// divisor limit register, reset to 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= {1'b1, {(tdpt_pkg::LIMIT_W-1){1'b0}}};
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	tdpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.strobe(strobe), .cmd(dcmd), .stat(dstat)
	);

	tdpt_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .PRIME_WIDTH(PRIME_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .limit(limit_q),
		.cmd(dcmd), .stat(dstat), .out_item(out_item)
	);
endmodule

// File: verif/trial_division_prime_tester_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_tester_tb
// self-checking bench for the trial division prime tester
// ----------------------------------------------------------------------------
// a queue of commands (clear, append, test, unused code) feeds a bursty
// driver; each accepted item runs through a local copy of the prime table
// and divisor limit to produce the expected result, which the monitor
// compares field by field with every strobed result. the divisor limit is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module trial_division_prime_tester_tb;

	localparam int DEPTH      = 4096;
	localparam int IDLE_LIMIT = 40000;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	tdpt_pkg::in_item_t            in_item;
	logic                          strobe;
	tdpt_pkg::out_item_t           out_item;
	logic                          limit_we;
	logic [tdpt_pkg::LIMIT_W-1:0]  limit_wdata;

	trial_division_prime_tester dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.in_item     (in_item),
		.strobe      (strobe),
		.out_item    (out_item),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// local copy of the block's state
	logic [31:0]                  primes [DEPTH];
	int unsigned                  prime_count;
	logic [tdpt_pkg::LIMIT_W-1:0] div_limit;

	tdpt_pkg::in_item_t  pending_items [$];
	tdpt_pkg::out_item_t expected_results [$];
	int                  errors;
	int                  idle_cycles;
	int                  gen_count; // entry count as the generator sees it

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// walk the table in order, first divisor makes it composite
	function automatic logic trial_divide(input logic [63:0] cand);
		logic [63:0] p;
		for (int j = 0; j < prime_count; j++) begin
			p = {32'd0, primes[j]};
			if (p != 0 && cand % p == 0)
				return 1'b0;
			// division first, then the limit check
			if ({31'd0, p} > {30'd0, div_limit})
				break;
		end
		return 1'b1;
	endfunction

	function automatic tdpt_pkg::out_item_t predict_result(input tdpt_pkg::in_item_t it);
		tdpt_pkg::out_item_t r;
		r = '0;
		r.echo_value = it.value;
		case (tdpt_pkg::cmd_t'(it.command))
			tdpt_pkg::CMD_CLEAR: begin
				prime_count = 0;
			end
			tdpt_pkg::CMD_APPEND: begin
				// oversize is checked before full
				if (it.value > 64'hFFFF_FFFF)
					r.status = tdpt_pkg::ST_OVERSIZE;
				else if (prime_count >= DEPTH)
					r.status = tdpt_pkg::ST_FULL;
				else begin
					primes[prime_count] = it.value[31:0];
					prime_count++;
				end
			end
			tdpt_pkg::CMD_TEST: begin
				r.prime_flag = trial_divide(it.value);
				r.test_done  = 1'b1;
			end
			default: ; // unused code changes nothing
		endcase
		r.table_entries = prime_count[tdpt_pkg::COUNT_W-1:0];
		return r;
	endfunction

	// driver: bursts of items with random gaps
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		tdpt_pkg::in_item_t nxt;
		if (!arst_n) begin
			start      <= 1'b0;
			in_item    <= '0;
			burst_left <= 4;
			gap_left   <= 0;
		end else begin
			if (start && !busy)
				expected_results.insert(expected_results.size(), predict_result(in_item));
			if (start && busy) begin
				// hold the item until taken
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start    <= 1'b0;
			end else if (pending_items.size() > 0) begin
				nxt = pending_items.pop_front();
				in_item <= nxt;
				start   <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					// some bursts run back to back with no gap
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else
					burst_left <= burst_left - 1;
			end else
				start <= 1'b0;
		end
	end

	// monitor: every strobe answers the oldest outstanding item
	always @(posedge clk) begin
		tdpt_pkg::out_item_t want;
		if (arst_n) begin
			if (strobe) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", 64'd1, 64'd0);
				end else begin
					want = expected_results.pop_front();
					if (out_item.status !== want.status)
						report("status", 64'(out_item.status), 64'(want.status));
					if (out_item.prime_flag !== want.prime_flag)
						report("prime_flag", 64'(out_item.prime_flag),
							64'(want.prime_flag));
					if (out_item.test_done !== want.test_done)
						report("test_done", 64'(out_item.test_done),
							64'(want.test_done));
					if (out_item.echo_value !== want.echo_value)
						report("echo_value", out_item.echo_value, want.echo_value);
					if (out_item.table_entries !== want.table_entries)
						report("table_entries", 64'(out_item.table_entries),
							64'(want.table_entries));
				end
			end
			// watchdog on cycles where nothing moves
			if (strobe || (start && !busy))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic add_item(input tdpt_pkg::cmd_t c, input logic [63:0] v);
		tdpt_pkg::in_item_t it;
		it.command = c;
		it.value   = v;
		pending_items.insert(pending_items.size(), it);
		if (c == tdpt_pkg::CMD_CLEAR)
			gen_count = 0;
		else if (c == tdpt_pkg::CMD_APPEND && v <= 64'hFFFF_FFFF && gen_count < DEPTH)
			gen_count++;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || start || busy || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [tdpt_pkg::LIMIT_W-1:0] v);
		limit_we    <= 1'b1;
		limit_wdata <= v;
		@(posedge clk);
		div_limit = v;
		limit_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (gen_count > 24 || k < 6)
				add_item(tdpt_pkg::CMD_CLEAR, {$urandom, $urandom});
			else if (k < 38)
				add_item(tdpt_pkg::CMD_APPEND, 64'($urandom_range(2, 300)));
			else if (k < 42)
				add_item(tdpt_pkg::CMD_APPEND, {$urandom, $urandom} | 64'h1_0000_0000);
			else if (k < 45)
				add_item(tdpt_pkg::CMD_APPEND, {32'd0, $urandom});
			else if (k < 47)
				add_item(tdpt_pkg::CMD_APPEND, 64'($urandom_range(0, 1)));
			else if (k < 50)
				add_item(tdpt_pkg::CMD_NONE, {$urandom, $urandom});
			else if (k < 75)
				add_item(tdpt_pkg::CMD_TEST, 64'($urandom_range(0, 100000)));
			else if (k < 95)
				add_item(tdpt_pkg::CMD_TEST, {$urandom, $urandom});
			else
				add_item(tdpt_pkg::CMD_TEST, $urandom_range(0, 1) ? 64'd0 : '1);
		end
	endtask

	initial begin
		errors      = 0;
		idle_cycles = 0;
		gen_count   = 0;
		prime_count = 0;
		div_limit   = 33'h1_0000_0000;
		limit_we    = 1'b0;
		limit_wdata = '0;
		arst_n      = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_limit(33'h1_0000_0000);

		// directed: empty table, unused code, zero and one entries, extremes
		add_item(tdpt_pkg::CMD_TEST, 64'd97);
		add_item(tdpt_pkg::CMD_NONE, '1);
		add_item(tdpt_pkg::CMD_APPEND, 64'd2);
		add_item(tdpt_pkg::CMD_APPEND, 64'd3);
		add_item(tdpt_pkg::CMD_APPEND, 64'd0);
		add_item(tdpt_pkg::CMD_APPEND, 64'd5);
		add_item(tdpt_pkg::CMD_APPEND, 64'd7);
		add_item(tdpt_pkg::CMD_TEST, 64'd0);
		add_item(tdpt_pkg::CMD_TEST, '1);
		add_item(tdpt_pkg::CMD_TEST, 64'd35);
		add_item(tdpt_pkg::CMD_TEST, 64'd121);
		add_item(tdpt_pkg::CMD_APPEND, 64'h1_0000_0000);
		add_item(tdpt_pkg::CMD_APPEND, 64'hFFFF_FFFF);
		add_item(tdpt_pkg::CMD_APPEND, '1);
		add_item(tdpt_pkg::CMD_TEST, 64'hFFFF_FFFF);
		add_item(tdpt_pkg::CMD_TEST, 64'hAAAA_AAAA_5555_5555);
		add_item(tdpt_pkg::CMD_APPEND, 64'd1);
		add_item(tdpt_pkg::CMD_TEST, 64'd11);
		add_item(tdpt_pkg::CMD_CLEAR, '1);
		add_item(tdpt_pkg::CMD_TEST, 64'd4);
		wait_drained();

		// limit zero: only the first entry is tried
		write_limit('0);
		add_item(tdpt_pkg::CMD_APPEND, 64'd3);
		add_item(tdpt_pkg::CMD_APPEND, 64'd13);
		add_item(tdpt_pkg::CMD_APPEND, 64'h2_0000_0000);
		add_item(tdpt_pkg::CMD_TEST, 64'd4);
		add_item(tdpt_pkg::CMD_TEST, 64'd9);
		add_item(tdpt_pkg::CMD_CLEAR, 64'd0);
		wait_drained();

		write_limit('1);
		random_phase(65);
		wait_drained();
		write_limit('0);
		random_phase(65);
		wait_drained();
		write_limit(33'($urandom_range(2, 60)));
		random_phase(65);
		wait_drained();
		write_limit(33'h1_0000_0000);
		random_phase(65);
		wait_drained();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
